### sv/ven_pkg.sv
// Package for the vector Euclidean norm block: sizes, queue entry and
// status structs shared by the front end, the queue and the root unit.
// No dependencies.
package ven_pkg;

  // Sample and accumulator sizes
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 47;

  // Fixed field widths of the channels
  localparam int SAMPLE_W = 16;
  localparam int NORM_W   = 24;

  // Derived widths
  localparam int RAW_BITS      = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int SUM_EXT_BITS  = ((ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS) + 1;
  localparam int ROOT_BITS     = (ACC_BITS + 1) / 2;
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 2;
  localparam int ROOT_EXT_BITS = (ROOT_BITS > NORM_W) ? ROOT_BITS : NORM_W;
  localparam int STEP_BITS     = $clog2(ROOT_BITS);

  // Largest norm the result field holds
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  // Queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // One finished vector sum waiting for its root
  typedef struct packed {
    logic [ACC_BITS-1:0] sum;
    logic                ovf;
  } vec_sum_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 full;
    logic                 empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } root_status_t;

endpackage

### sv/ven_in_if.sv
// Input stream channel: one vector element per beat.
// Depends on ven_pkg for the field width.
interface ven_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ven_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

### sv/ven_out_if.sv
// Result stream channel: one norm per vector.
// Depends on ven_pkg for the field width.
interface ven_out_if;
  logic                        valid;
  logic                        ready;
  logic [ven_pkg::NORM_W-1:0]  norm;
  logic                        saturated;

  modport source (output valid, output norm, output saturated, input ready);
  modport sink (input valid, input norm, input saturated, output ready);
endinterface

### sv/ven_front.sv
// Front end: magnitude and square of each sample, saturating accumulation,
// hand-off of the finished sum on the last beat. Uses ven_pkg, ven_in_if.
module ven_front (
  input  logic              clk,
  input  logic              rst,
  ven_in_if.sink            samples,
  output logic              push,
  output ven_pkg::vec_sum_t push_data,
  input  logic              q_full
);
  import ven_pkg::*;

  logic [RAW_BITS-1:0]     raw;
  logic [SAMPLE_BITS-1:0]  v;
  logic [SAMPLE_BITS-1:0]  mag;
  logic [SQ_BITS-1:0]      sq;

  logic                    s1_valid;
  logic                    s1_last;
  logic [SQ_BITS-1:0]      s1_sq;

  logic [ACC_BITS-1:0]     acc;
  logic                    ovf;

  logic [SUM_EXT_BITS-1:0] sum_ext;
  logic                    over;
  logic [ACC_BITS-1:0]     acc_new;
  logic                    ovf_new;
  logic                    advance;

  // Magnitude of the two's complement sample, squared exactly
  always_comb begin
    raw = RAW_BITS'($unsigned(samples.sample));
    v   = raw[SAMPLE_BITS-1:0];
    mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    sq  = SQ_BITS'(mag) * SQ_BITS'(mag);
  end

  // Saturating add into the accumulator
  always_comb begin
    sum_ext = SUM_EXT_BITS'(acc) + SUM_EXT_BITS'(s1_sq);
    over    = sum_ext > SUM_EXT_BITS'({ACC_BITS{1'b1}});
    acc_new = over ? {ACC_BITS{1'b1}} : sum_ext[ACC_BITS-1:0];
    ovf_new = ovf | over;
  end

  // A last beat waits in stage 1 until the queue has room
  assign advance       = !(s1_valid && s1_last && q_full);
  assign samples.ready = !s1_valid || advance;
  assign push          = s1_valid && s1_last && !q_full;
  assign push_data     = '{sum: acc_new, ovf: ovf_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
      ovf      <= 1'b0;
    end else begin
      if (s1_valid && advance) begin
        if (s1_last) begin
          acc <= '0;
          ovf <= 1'b0;
        end else begin
          acc <= acc_new;
          ovf <= ovf_new;
        end
      end
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_sq   <= sq;
      s1_last <= samples.last;
    end
  end

endmodule

### sv/ven_queue.sv
// Short queue of finished vector sums between front end and root unit.
// Uses ven_pkg.
module ven_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ven_pkg::vec_sum_t  push_data,
  input  logic               pop,
  output ven_pkg::vec_sum_t  pop_data,
  output ven_pkg::q_status_t status
);
  import ven_pkg::*;

  vec_sum_t             entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign pop_data     = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = count == QCNT_BITS'(QDEPTH);
  assign status.empty = count == '0;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### sv/ven_sqrt.sv
// Back end: floor square root, one root bit per cycle, and the result
// register. Uses ven_pkg, ven_out_if.
module ven_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  pop,
  input  ven_pkg::vec_sum_t     pop_data,
  ven_out_if.source             result,
  output ven_pkg::root_status_t status
);
  import ven_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t                   state;
  logic [RAD_BITS-1:0]      rad;
  logic [REM_BITS-1:0]      rem;
  logic [ROOT_BITS-1:0]     root;
  logic [STEP_BITS-1:0]     step;
  logic                     ovf;

  logic [REM_BITS-1:0]      rem_sh;
  logic [REM_BITS-1:0]      trial;
  logic                     ge;
  logic [REM_BITS-1:0]      rem_next;
  logic [ROOT_BITS-1:0]     root_next;
  logic [ROOT_EXT_BITS-1:0] root_ext;
  logic [NORM_W-1:0]        norm_sat;
  logic                     out_free;

  // One restoring step: bring in two radicand bits, try root*4+1
  always_comb begin
    rem_sh    = {rem[REM_BITS-3:0], rad[RAD_BITS-1 -: 2]};
    trial     = {root, 2'b01};
    ge        = rem_sh >= trial;
    rem_next  = ge ? (rem_sh - trial) : rem_sh;
    root_next = {root[ROOT_BITS-2:0], ge};
  end

  // Clamp the root to the result field
  always_comb begin
    root_ext = ROOT_EXT_BITS'(root);
    norm_sat = (root_ext > ROOT_EXT_BITS'(NORM_MAX)) ? NORM_MAX : root_ext[NORM_W-1:0];
  end

  assign out_free      = !result.valid || result.ready;
  assign pop           = (state == IDLE) && !q_empty;
  assign status.busy   = state != IDLE;
  assign status.finish = (state == FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result.valid <= 1'b0;
    end else begin
      // Result valid: set when a finished root loads, cleared once taken
      if ((state == FINISH) && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            rad   <= RAD_BITS'(pop_data.sum);
            ovf   <= pop_data.ovf;
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          rem  <= rem_next;
          root <= root_next;
          rad  <= {rad[RAD_BITS-3:0], 2'b00};
          if (step == STEP_BITS'(ROOT_BITS - 1)) begin
            state <= FINISH;
          end else begin
            step <= step + 1'b1;
          end
        end
        FINISH: begin
          if (out_free) begin
            result.norm      <= norm_sat;
            result.saturated <= ovf;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### sv/vector_euclidean_norm.sv
// Top level of the vector Euclidean norm block: front end, sum queue and
// root unit. Uses ven_pkg, ven_in_if, ven_out_if, ven_front, ven_queue, ven_sqrt.
//
//   channel   dir  fields                     beat
//   samples   in   sample[15:0] s, last       one vector element
//   result    out  norm[23:0], saturated      one norm per vector
//
// Elements are taken one per cycle; a square is registered, then added.
// The root of each finished sum is found in the one-bit-per-cycle root
// unit, which takes a new sum only when idle; up to four sums wait in
// the queue, so short vectors stall the input only when the queue is
// full. Reset is synchronous and clears the accumulator, queue and
// result valid. A stalled result holds in its output register.
module vector_euclidean_norm (
  input  logic      clk,
  input  logic      rst,
  ven_in_if.sink    samples,
  ven_out_if.source result
);
  import ven_pkg::*;

  logic         push;
  vec_sum_t     push_data;
  logic         pop;
  vec_sum_t     pop_data;
  q_status_t    qstat;
  root_status_t rstat;

  ven_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push      (push),
    .push_data (push_data),
    .q_full    (qstat.full)
  );

  ven_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (qstat)
  );

  ven_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (qstat.empty),
    .pop      (pop),
    .pop_data (pop_data),
    .result   (result),
    .status   (rstat)
  );

`ifndef NO_ASSERTIONS
  // No result is pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // A new result appears only from a finished root
  a_result_from_root: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(rstat.finish))
    else $error("result raised without a finished root");

  // The root unit takes a sum only when one is queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty && !rstat.busy)
    else $error("pop from empty queue or while busy");

  // A queued sum never gets lost on a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> qstat.count != QCNT_BITS'(QDEPTH))
    else $error("push into full queue");
`endif

endmodule
